### hdl/byte_unstuffing_deframer_core_macros.svh
// Assertion macros for the byte unstuffing deframer.
// Every macro expects clk and rst_n in the scope where it is used.
`ifndef BYTE_UNSTUFFING_DEFRAMER_CORE_MACROS_SVH
`define BYTE_UNSTUFFING_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication.
`define BUD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bud_pkg.sv
// Shared types and constants of the byte unstuffing deframer.
// No dependencies; every other file but the macro header uses it.
package bud_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = 9;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W       = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_START  = 2'd0;
    localparam logic [IDX_W-1:0] REG_STOP   = 2'd1;
    localparam logic [IDX_W-1:0] REG_ESCAPE = 2'd2;

    localparam logic [7:0] RST_START  = 8'd2;
    localparam logic [7:0] RST_STOP   = 8'd3;
    localparam logic [7:0] RST_ESCAPE = 8'd27;

    localparam logic [7:0] ESC_OFFSET = 8'd2;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_START_IN  = 2'd1;
    localparam logic [1:0] ST_BAD_FINAL = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] escape_byte;
    } bud_cfg_t;

    // One queued step: an optional data result followed by an optional end result
    typedef struct packed {
        logic             has_data;
        logic [7:0]       data_byte;
        logic             has_status;
        logic [1:0]       status;
        logic [LEN_W-1:0] payload_length;
    } bud_entry_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } bud_phase_t;

endpackage

### hdl/bud_if.sv
// Handshake channels of the byte unstuffing deframer.
// Depends on bud_pkg for widths.
interface bud_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;
    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface bud_out_if;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [7:0]               data_byte;
    logic [1:0]               status;
    logic [bud_pkg::LEN_W-1:0] payload_length;
    logic                     last_in_step;
    modport source (output valid, output kind, output data_byte, output status,
                    output payload_length, output last_in_step, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input payload_length, input last_in_step, output ready);
endinterface

interface bud_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bud_pkg::IDX_W-1:0] index;
    logic [7:0]                data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bud_front.sv
// Front end: accepts received bytes, tracks frame state, queues results.
// Depends on bud_pkg and bud_if.
module bud_front
    import bud_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bud_in_if.sink         in_ch,
    input  bud_cfg_t       cfg,
    input  logic           q_full,
    output logic           q_push,
    output bud_entry_t     q_entry
);

    logic             begin_reg, begin_next;
    logic             esc_reg, esc_next;
    logic             disc_reg, disc_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= 1'b1;
            esc_reg   <= 1'b0;
            disc_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            begin_reg <= begin_next;
            esc_reg   <= esc_next;
            disc_reg  <= disc_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        logic       want_data;
        logic [7:0] dbyte;
        logic       want_status;
        logic [1:0] code;
        logic       clear;
        logic       cnt_full;
        logic       data_ok;
        logic [7:0] b;
        logic       fin;

        b           = in_ch.in_byte;
        fin         = in_ch.is_final;
        want_data   = 1'b0;
        dbyte       = b;
        want_status = 1'b0;
        code        = ST_OK;
        clear       = 1'b0;
        begin_next  = begin_reg;
        esc_next    = esc_reg;
        disc_next   = disc_reg;

        if (disc_reg)
        begin
            clear = fin;
        end
        else if (esc_reg)
        begin
            esc_next    = 1'b0;
            want_data   = 1'b1;
            dbyte       = b - ESC_OFFSET;
            want_status = fin;
            clear       = fin;
        end
        else if (begin_reg && b == cfg.start_byte)
        begin
            begin_next  = 1'b0;
            want_status = fin;
            clear       = fin;
        end
        else if (fin)
        begin
            want_status = 1'b1;
            code        = (b == cfg.stop_byte || b == 8'd0) ? ST_OK : ST_BAD_FINAL;
            clear       = 1'b1;
        end
        else
        begin
            begin_next = 1'b0;
            if (b == cfg.start_byte)
            begin
                want_status = 1'b1;
                code        = ST_START_IN;
                disc_next   = 1'b1;
            end
            else if (b == cfg.stop_byte)
            begin
                want_status = 1'b1;
                disc_next   = 1'b1;
            end
            else if (b == cfg.escape_byte)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                want_data = 1'b1;
            end
        end

        // Drop data once the payload limit is reached
        cnt_full   = count_reg >= LEN_W'(MAX_PAYLOAD);
        data_ok    = want_data && !cnt_full;
        count_next = data_ok ? count_reg + 1'b1 : count_reg;
        ovf_next   = ovf_reg || (want_data && cnt_full);

        if (code == ST_OK && ovf_next)
            code = ST_TOO_LONG;

        q_entry.has_data       = data_ok;
        q_entry.data_byte      = dbyte;
        q_entry.has_status     = want_status;
        q_entry.status         = code;
        q_entry.payload_length = count_next;
        q_push                 = accept && (data_ok || want_status);

        if (clear)
        begin
            begin_next = 1'b1;
            esc_next   = 1'b0;
            disc_next  = 1'b0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

endmodule

### hdl/bud_fifo.sv
// Short queue of step results between front and back end.
// Depends on bud_pkg and the assertion macro header.
`include "byte_unstuffing_deframer_core_macros.svh"
module bud_fifo
    import bud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bud_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output bud_entry_t head_entry
);

    bud_entry_t       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    `BUD_ASSERT_IMPL(a_push_not_full, push, !full, "push into full queue")
    `BUD_ASSERT_IMPL(a_pop_not_empty, pop, head_valid, "pop from empty queue")
    `BUD_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "queue count out of range")
    `BUD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count missed push")

endmodule

### hdl/bud_back.sv
// Back end: drains queued steps, one result word per cycle while the receiver is ready.
// Depends on bud_pkg and bud_if.
module bud_back
    import bud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  bud_entry_t head_entry,
    output logic       pop,
    bud_out_if.source  out_ch
);

    bud_phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_FIRST;
        else
            phase_reg <= phase_next;
    end

    always_comb
    begin
        logic show_data;
        logic accept;

        show_data = (phase_reg == PH_FIRST) && head_entry.has_data;
        accept    = head_valid && out_ch.ready;

        out_ch.valid          = head_valid;
        out_ch.kind           = show_data ? KIND_DATA : KIND_END;
        out_ch.data_byte      = show_data ? head_entry.data_byte : 8'd0;
        out_ch.status         = show_data ? ST_OK : head_entry.status;
        out_ch.payload_length = show_data ? '0 : head_entry.payload_length;
        out_ch.last_in_step   = !show_data || !head_entry.has_status;

        phase_next = phase_reg;
        pop        = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (accept)
                begin
                    // Hold the entry when its end result still has to go
                    if (head_entry.has_data && head_entry.has_status)
                        phase_next = PH_SECOND;
                    else
                        pop = 1'b1;
                end
            end
            PH_SECOND:
            begin
                if (accept)
                begin
                    pop        = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

endmodule

### hdl/byte_unstuffing_deframer_core.sv
// Byte unstuffing deframer, top level: config registers, front, queue, back.
// Depends on bud_pkg, bud_if, bud_front, bud_fifo and bud_back.
// A result word is queued when its byte is accepted and offered once the words ahead of it have gone.
// Throughput: one byte per cycle while the queue is not full; a byte that gives data and end
// status yields two output words, absorbed by the four-entry queue.
// Reset: rst_n clears frame state and queue and reloads the delimiter registers.
module byte_unstuffing_deframer_core
    import bud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bud_in_if.sink    in_ch,
    bud_cfg_if.sink   cfg_ch,
    bud_out_if.source out_ch
);

    bud_cfg_t   cfg_reg;
    logic       q_full;
    logic       q_push;
    bud_entry_t q_entry;
    logic       q_pop;
    logic       head_valid;
    bud_entry_t head_entry;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= RST_START;
            cfg_reg.stop_byte   <= RST_STOP;
            cfg_reg.escape_byte <= RST_ESCAPE;
        end
        else if (cfg_ch.valid)
        begin
            // Ignore indexes beyond the register list
            unique case (cfg_ch.index)
                REG_START:  cfg_reg.start_byte  <= cfg_ch.data;
                REG_STOP:   cfg_reg.stop_byte   <= cfg_ch.data;
                REG_ESCAPE: cfg_reg.escape_byte <= cfg_ch.data;
                default:    ;
            endcase
        end
    end

    bud_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    bud_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    bud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

endmodule

### dv/tb_top.sv
// Self-checking testbench for byte_unstuffing_deframer_core.
// Depends on bud_pkg and the channel interfaces in bud_if; drives frames through the
// input channel, rewrites the delimiters between phases and checks every result word.
module tb_top;
    import bud_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_GAP       = 19;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 16;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic [1:0]       status;
        logic [LEN_W-1:0] payload_length;
        logic             last_in_step;
    } deframed_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bud_in_if  in_ch();
    bud_cfg_if cfg_ch();
    bud_out_if out_ch();

    byte_unstuffing_deframer_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // Predicted delimiters and frame state
    logic [7:0] delim_start;
    logic [7:0] delim_stop;
    logic [7:0] delim_escape;
    logic       at_begin;
    logic       esc_pending;
    logic       dropping;
    logic       overflowed;
    int         payload_count;

    deframed_word_t expected_words[$];
    deframed_word_t step_words[$];
    int mismatch_count = 0;
    int bytes_accepted = 0;
    bit in_burst       = 1'b0;
    bit out_burst      = 1'b0;
    bit hold_request   = 1'b0;

    always #5 clk = ~clk;

    function automatic void restart_frame();
        at_begin      = 1'b1;
        esc_pending   = 1'b0;
        dropping      = 1'b0;
        overflowed    = 1'b0;
        payload_count = 0;
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        deframed_word_t w;
        if (payload_count >= MAX_PAYLOAD)
        begin
            overflowed = 1'b1;
            return;
        end
        payload_count++;
        w           = '0;
        w.kind      = KIND_DATA;
        w.data_byte = b;
        step_words.push_back(w);
    endfunction

    function automatic void emit_status(input logic [1:0] code);
        deframed_word_t w;
        w                = '0;
        w.kind           = KIND_END;
        w.status         = (code == ST_OK && overflowed) ? ST_TOO_LONG : code;
        w.payload_length = payload_count[LEN_W-1:0];
        step_words.push_back(w);
    endfunction

    // Work out the result words that one accepted byte causes
    function automatic void predict_deframe(input logic [7:0] b, input logic fin);
        step_words.delete();
        if (dropping)
        begin
            if (fin)
                restart_frame();
            return;
        end
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            emit_data(b - ESC_OFFSET);
            if (fin)
            begin
                emit_status(ST_OK);
                restart_frame();
            end
        end
        else if (at_begin && b == delim_start)
        begin
            at_begin = 1'b0;
            if (fin)
            begin
                emit_status(ST_OK);
                restart_frame();
            end
        end
        else if (fin)
        begin
            // check byte: never data, whatever delimiter it matches
            emit_status((b == delim_stop || b == 8'd0) ? ST_OK : ST_BAD_FINAL);
            restart_frame();
        end
        else
        begin
            at_begin = 1'b0;
            if (b == delim_start)
            begin
                emit_status(ST_START_IN);
                dropping = 1'b1;
            end
            else if (b == delim_stop)
            begin
                emit_status(ST_OK);
                dropping = 1'b1;
            end
            else if (b == delim_escape)
                esc_pending = 1'b1;
            else
                emit_data(b);
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last_in_step = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return delim_start;
            1: return delim_stop;
            2: return delim_escape;
            3: return 8'd0;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void pick_idle_mode();
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
    endfunction

    // Offer one byte; valid stays high after acceptance so back-to-back words need no toggle
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.is_final <= fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_accepted++;
        predict_deframe(b, fin);
    endtask

    task automatic wait_idle();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (expected_words.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_words.size() > 0)
        begin
            $error("%0d expected result words never arrived", expected_words.size());
            mismatch_count++;
            expected_words.delete();
        end
        // let a byte with no result leave the pipeline before touching registers
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_delims(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e);
        logic [IDX_W-1:0] idx_list [4];
        logic [7:0]       vals [4];
        wait_idle();
        idx_list = '{REG_UNUSED, REG_START, REG_STOP, REG_ESCAPE};
        vals     = '{8'($urandom), s, p, e};
        foreach (idx_list[i])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            case (idx_list[i])
                REG_START:  delim_start  = vals[i];
                REG_STOP:   delim_stop   = vals[i];
                REG_ESCAPE: delim_escape = vals[i];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Data bytes, stuffed where they collide with a delimiter and now and then anyway
    task automatic send_payload(input int count);
        logic [7:0] p;
        repeat (count)
        begin
            p = 8'($urandom);
            if (p == delim_start || p == delim_stop || p == delim_escape
                || $urandom_range(0, 7) == 0)
            begin
                send_byte(delim_escape, 1'b0);
                send_byte(p + ESC_OFFSET, 1'b0);
            end
            else
                send_byte(p, 1'b0);
        end
    endtask

    task automatic send_random_frame();
        int len;
        int ender;
        if ($urandom_range(0, 9) >= 8)
        begin
            // noise: loose bytes, any of which may end the buffer; the last one always does
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_byte(pick_byte(), (i == len - 1) || ($urandom_range(0, 5) == 0));
            return;
        end
        if ($urandom_range(0, 9) != 0)
            send_byte(delim_start, 1'b0);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_payload(len);
        ender = $urandom_range(0, 5);
        case (ender)
            0: send_byte(delim_stop, 1'b1);
            1: send_byte(8'd0, 1'b1);
            2:
            begin
                send_byte(delim_escape, 1'b0);
                send_byte(8'($urandom), 1'b1);
            end
            3, 4:
            begin
                // early stop or a stray start, then drop up to the end of the buffer
                send_byte((ender == 3) ? delim_stop : delim_start, 1'b0);
                repeat ($urandom_range(0, 4)) send_byte(pick_byte(), 1'b0);
                send_byte(pick_byte(), 1'b1);
            end
            default: send_byte(pick_byte(), 1'b1);
        endcase
    endtask

    task automatic test_directed_frames();
        logic [8:0] steps [$];
        steps = '{
            // both byte extremes as data, closed by a final stop
            {1'b0, RST_START}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b1, RST_STOP},
            // start byte alone as the whole buffer
            {1'b1, RST_START},
            // escaped final byte, wrapping below zero
            {1'b0, RST_START}, {1'b0, RST_ESCAPE}, {1'b1, 8'h01},
            // escaped zero, then the escape byte in the check position
            {1'b0, RST_START}, {1'b0, RST_ESCAPE}, {1'b0, 8'h00}, {1'b1, RST_ESCAPE},
            // start inside the frame, remainder dropped
            {1'b0, RST_START}, {1'b0, 8'h10}, {1'b0, RST_START}, {1'b0, 8'h55}, {1'b1, 8'h66},
            // early stop, remainder dropped
            {1'b0, RST_START}, {1'b0, 8'h11}, {1'b0, RST_STOP}, {1'b1, RST_STOP},
            // no leading start, start byte as check byte, lone check bytes
            {1'b0, 8'h44}, {1'b1, RST_START},
            {1'b1, 8'hFF}, {1'b1, 8'h00}
        };
        foreach (steps[i])
            send_byte(steps[i][7:0], steps[i][8]);
    endtask

    task automatic test_payload_overflow();
        pick_idle_mode();
        send_byte(delim_start, 1'b0);
        send_payload(MAX_PAYLOAD + 1 + $urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0)
            send_byte(delim_stop, 1'b1);
        else
        begin
            // start inside the frame wins over the overflow
            send_byte(delim_start, 1'b0);
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        in_burst     = 1'b1;
        out_burst    = 1'b0;
        hold_request = 1'b1;
        send_byte(delim_start, 1'b0);
        send_payload(30);
        send_byte(delim_stop, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        logic [23:0] delim_sets [5];
        int          phase_start;
        delim_sets = '{
            {RST_START, RST_STOP, RST_ESCAPE},
            {8'h00, 8'hFF, 8'h7D},
            {8'hFF, 8'h00, 8'hFF},
            {8'h7E, 8'h7E, 8'h00},
            24'($urandom)
        };
        foreach (delim_sets[i])
        begin
            set_delims(delim_sets[i][23:16], delim_sets[i][15:8], delim_sets[i][7:0]);
            pick_idle_mode();
            phase_start = bytes_accepted;
            while (bytes_accepted - phase_start < PHASE_BYTES)
                send_random_frame();
        end
    endtask

    // Receiver: draw a stall per word, or hold off for a long stretch when asked
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap          = HOLD_CYCLES;
            end
            else
                gap = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        deframed_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: kind %0d data %0d status %0d length %0d",
                       out_ch.kind, out_ch.data_byte, out_ch.status, out_ch.payload_length);
                mismatch_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("kind", want.kind, out_ch.kind);
                check_field("data_byte", want.data_byte, out_ch.data_byte);
                check_field("status", want.status, out_ch.status);
                check_field("payload_length", want.payload_length, out_ch.payload_length);
                check_field("last_in_step", want.last_in_step, out_ch.last_in_step);
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= '0;
        in_ch.is_final <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        delim_start  = RST_START;
        delim_stop   = RST_STOP;
        delim_escape = RST_ESCAPE;
        restart_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_payload_overflow();
        test_backpressure();
        test_config_sweep();
        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $error("timeout: run did not finish");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
